@@ rtl/rle_pkg.sv @@
// rle_pkg: shared types and constants for the run-length text encoder
// no dependencies; imported by every module under rtl

package rle_pkg;

    localparam int unsigned LEN_W       = 16;
    localparam int unsigned MAX_RUN_DEF = 65535;
    localparam int unsigned NUM_DIGITS  = 5;
    localparam int unsigned DIGIT_IDX_W = 3;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_PTR_W     = 2;

    localparam logic [LEN_W-1:0] DIV10_MUL  = 16'd52429;
    localparam int unsigned      DIV10_SHR  = 19;
    localparam logic [7:0]       ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]       held_byte;
        logic [LEN_W-1:0] run_length;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/rle_front.sv @@
// rle_front: holds the pending run and pushes finished runs to the queue
// depends on rle_pkg

module rle_front
    import rle_pkg::*;
#(
    parameter int unsigned MAX_RUN = MAX_RUN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      raw_valid,
    output logic      raw_ready,
    input  in_beat_t  raw_beat,
    input  q_status_t q_status,
    output logic      push,
    output run_t      push_run
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_RUN);

    logic [7:0]       held_byte_reg;
    logic             run_active_reg;
    logic [LEN_W-1:0] run_length_reg;
    logic             accept;
    logic             extend;

    assign raw_ready = !q_status.full;
    assign accept    = raw_valid && raw_ready;
    assign extend    = (raw_beat.data_byte == held_byte_reg) && (run_length_reg < MaxLen);

    assign push = accept && run_active_reg && (raw_beat.end_of_stream || !extend);
    assign push_run.held_byte  = held_byte_reg;
    assign push_run.run_length = run_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            run_active_reg <= 1'b0;
            run_length_reg <= '0;
        end
        else if (accept)
        begin
            if (raw_beat.end_of_stream)
            begin
                held_byte_reg  <= '0;
                run_active_reg <= 1'b0;
                run_length_reg <= '0;
            end
            else if (run_active_reg && extend)
            begin
                run_length_reg <= run_length_reg + LEN_W'(1);
            end
            else
            begin
                held_byte_reg  <= raw_beat.data_byte;
                run_active_reg <= 1'b1;
                run_length_reg <= LEN_W'(1);
            end
        end
    end

endmodule

@@ rtl/rle_queue.sv @@
// rle_queue: short run queue between front and back
// depends on rle_pkg

module rle_queue
    import rle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_t      push_run,
    input  logic      pop,
    output run_t      pop_run,
    output q_status_t q_status
);

    run_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W:0] wr_ptr_reg;
    logic [Q_PTR_W:0] rd_ptr_reg;

    assign q_status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign q_status.full  = (wr_ptr_reg[Q_PTR_W] != rd_ptr_reg[Q_PTR_W])
                         && (wr_ptr_reg[Q_PTR_W-1:0] == rd_ptr_reg[Q_PTR_W-1:0]);
    assign pop_run = entry_reg[rd_ptr_reg[Q_PTR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !q_status.full)
        begin
            entry_reg[wr_ptr_reg[Q_PTR_W-1:0]] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !q_status.full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !q_status.empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/rle_back.sv @@
// rle_back: turns one queued run into decimal count digits and the run byte
// depends on rle_pkg

module rle_back
    import rle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  run_t      pop_run,
    output logic      pop,
    output logic      code_valid,
    input  logic      code_ready,
    output out_beat_t code_beat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT,
        S_BYTE
    } state_t;

    state_t                 state_reg;
    logic [LEN_W-1:0]       n_reg;
    logic [7:0]             byte_reg;
    logic [DIGIT_IDX_W-1:0] nd_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [3:0]             digit_reg [NUM_DIGITS];
    out_beat_t              out_reg;
    logic                   out_valid_reg;

    logic [2*LEN_W-1:0]     prod;
    logic [LEN_W-1:0]       quot;
    logic [LEN_W-1:0]       rem;
    logic                   slot_free;
    logic                   emit_load;

    // divide by ten through the reciprocal
    assign prod = (2*LEN_W)'(n_reg) * (2*LEN_W)'(DIV10_MUL);
    assign quot = LEN_W'(prod[2*LEN_W-1:DIV10_SHR]);
    assign rem  = n_reg - ((quot << 3) + (quot << 1));

    assign slot_free  = !out_valid_reg || code_ready;
    assign emit_load  = slot_free && ((state_reg == S_EMIT) || (state_reg == S_BYTE));
    assign pop        = (state_reg == S_IDLE) && !q_status.empty;
    assign code_valid = out_valid_reg;
    assign code_beat  = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CONV)
        begin
            digit_reg[nd_reg] <= rem[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            byte_reg      <= '0;
            nd_reg        <= '0;
            idx_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && code_ready && !emit_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        n_reg     <= pop_run.run_length;
                        byte_reg  <= pop_run.held_byte;
                        nd_reg    <= '0;
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    n_reg  <= quot;
                    nd_reg <= nd_reg + 1'b1;
                    if (quot == '0 || nd_reg == DIGIT_IDX_W'(NUM_DIGITS - 1))
                    begin
                        idx_reg   <= nd_reg;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_reg.out_byte    <= ASCII_ZERO + {4'd0, digit_reg[idx_reg]};
                        out_reg.last_of_run <= 1'b0;
                        out_valid_reg       <= 1'b1;
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_BYTE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                end
                S_BYTE:
                begin
                    if (slot_free)
                    begin
                        out_reg.out_byte    <= byte_reg;
                        out_reg.last_of_run <= 1'b1;
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/rle_decimal_text_encoder.sv @@
// rle_decimal_text_encoder: run-length encoder writing runs as decimal text
// depends on rle_pkg, rle_front, rle_queue, rle_back
//
// channel | direction | handshake              | beat
// raw     | in        | raw_valid / raw_ready  | in_beat_t  (data_byte, end_of_stream)
// code    | out       | code_valid / code_ready| out_beat_t (out_byte, last_of_run)
//
// one raw beat per cycle while the run queue has room; a beat that ends a run
// queues it, and the back end takes one run at a time, finds each count digit
// by division by ten, then emits the output beats (digits, then the run byte)
// reset clears run state, queue pointers and the output register
// raw_ready drops only when the four-entry run queue is full; code stalls
// hold the output register and back up into the queue

module rle_decimal_text_encoder
    import rle_pkg::*;
#(
    parameter int unsigned MAX_RUN = MAX_RUN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      raw_valid,
    output logic      raw_ready,
    input  in_beat_t  raw_beat,
    output logic      code_valid,
    input  logic      code_ready,
    output out_beat_t code_beat
);

    q_status_t q_status;
    logic      push;
    run_t      push_run;
    logic      pop;
    run_t      pop_run;

    rle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw_beat  (raw_beat),
        .q_status  (q_status),
        .push      (push),
        .push_run  (push_run)
    );

    rle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .pop_run  (pop_run),
        .q_status (q_status)
    );

    rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_run    (pop_run),
        .pop        (pop),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_beat  (code_beat)
    );

endmodule
